/* design/rri_pkg.sv */
// Shared types and constants for the ray-ray intersection pipeline.
// No dependencies; used by rri_div, ray_ray_intersection_test and its bench.
package rri_pkg;

    localparam int COORD_WIDTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int TPAR_FRAC         = 16;
    localparam int TPAR_BITS         = 40;
    localparam int THR_WIDTH         = 32;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 32'd1;

    typedef struct packed {
        logic live;
        logic neg_a;
        logic neg_b;
        logic sat_a;
        logic sat_b;
    } rri_flags_t;

endpackage

/* design/rri_div.sv */
// Pipelined restoring divider, two numerators over one shared denominator.
// One quotient bit per stage, TPAR_BITS stages. Depends on rri_pkg.
module rri_div
    import rri_pkg::*;
#(
    parameter int NUM_WIDTH = 4 * COORD_WIDTH_DEF + 1 + TPAR_FRAC,
    parameter int DEN_WIDTH = 4 * COORD_WIDTH_DEF,
    parameter int SB_WIDTH  = 14 * COORD_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [NUM_WIDTH-1:0] num_a,
    input  logic [NUM_WIDTH-1:0] num_b,
    input  logic [DEN_WIDTH-1:0] den,
    input  rri_flags_t           flags_in,
    input  logic [SB_WIDTH-1:0]  sb_in,
    output logic                 out_valid,
    output logic [TPAR_BITS-1:0] quo_a,
    output logic [TPAR_BITS-1:0] quo_b,
    output rri_flags_t           flags_out,
    output logic [SB_WIDTH-1:0]  sb_out
);

    localparam int QW = TPAR_BITS;
    localparam int XW = (DEN_WIDTH + QW > NUM_WIDTH) ? DEN_WIDTH + QW : NUM_WIDTH;

    logic [QW-1:0]        v_reg;
    logic [NUM_WIDTH-1:0] ra_reg  [QW];
    logic [NUM_WIDTH-1:0] rb_reg  [QW];
    logic [NUM_WIDTH-1:0] ra_next [QW];
    logic [NUM_WIDTH-1:0] rb_next [QW];
    logic [QW-1:0]        qa_reg  [QW];
    logic [QW-1:0]        qb_reg  [QW];
    logic [QW-1:0]        qa_next [QW];
    logic [QW-1:0]        qb_next [QW];
    logic [DEN_WIDTH-1:0] d_reg   [QW];
    rri_flags_t           f_reg   [QW];
    logic [SB_WIDTH-1:0]  sb_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int SH = QW - 1 - k;
        logic [NUM_WIDTH-1:0] ra_prev;
        logic [NUM_WIDTH-1:0] rb_prev;
        logic [QW-1:0]        qa_prev;
        logic [QW-1:0]        qb_prev;
        logic [DEN_WIDTH-1:0] d_prev;
        logic [XW-1:0]        ds;
        logic                 ge_a;
        logic                 ge_b;

        if (k == 0) begin : g_first
            assign ra_prev = num_a;
            assign rb_prev = num_b;
            assign qa_prev = '0;
            assign qb_prev = '0;
            assign d_prev  = den;
        end
        else begin : g_rest
            assign ra_prev = ra_reg[k-1];
            assign rb_prev = rb_reg[k-1];
            assign qa_prev = qa_reg[k-1];
            assign qb_prev = qb_reg[k-1];
            assign d_prev  = d_reg[k-1];
        end

        assign ds   = XW'(d_prev) << SH;
        assign ge_a = XW'(ra_prev) >= ds;
        assign ge_b = XW'(rb_prev) >= ds;
        assign ra_next[k] = ge_a ? NUM_WIDTH'(XW'(ra_prev) - ds) : ra_prev;
        assign rb_next[k] = ge_b ? NUM_WIDTH'(XW'(rb_prev) - ds) : rb_prev;
        assign qa_next[k] = {qa_prev[QW-2:0], ge_a};
        assign qb_next[k] = {qb_prev[QW-2:0], ge_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[QW-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                ra_reg[k] <= ra_next[k];
                rb_reg[k] <= rb_next[k];
                qa_reg[k] <= qa_next[k];
                qb_reg[k] <= qb_next[k];
            end
            d_reg[0]  <= den;
            f_reg[0]  <= flags_in;
            sb_reg[0] <= sb_in;
            for (int k = 1; k < QW; k++)
            begin
                d_reg[k]  <= d_reg[k-1];
                f_reg[k]  <= f_reg[k-1];
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo_a     = qa_reg[QW-1];
    assign quo_b     = qb_reg[QW-1];
    assign flags_out = f_reg[QW-1];
    assign sb_out    = sb_reg[QW-1];

    // remainder must end below the divisor whenever the quotient did not overflow
    a_rem_a: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[QW-1] && f_reg[QW-1].live && !f_reg[QW-1].sat_a
        |-> XW'(ra_reg[QW-1]) < XW'(d_reg[QW-1]))
        else $error("lane a remainder not below divisor");

    a_rem_b: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[QW-1] && f_reg[QW-1].live && !f_reg[QW-1].sat_b
        |-> XW'(rb_reg[QW-1]) < XW'(d_reg[QW-1]))
        else $error("lane b remainder not below divisor");

    a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && f_reg[0].live |-> d_reg[0] != '0)
        else $error("live item entered divider with zero divisor");

endmodule

/* design/ray_ray_intersection_test.sv */
// Ray-ray intersection test, fixed point, fully pipelined top level.
// Depends on rri_pkg and rri_div.
//
//   channel   signals                                  transfer
//   cfg       cfg_write_en, cfg_write_data             write on enable, no wait
//   in        in_valid/in_ready, two rays + limits     valid & ready
//   out       out_valid/out_ready, intersects          valid & ready
//
// One item per cycle sustained while results are taken. Path from acceptance to result:
// 5 front stages, 40 divider stages (one quotient bit each), 5 back stages.
// Reset clears valid bits and loads the threshold with 1.
// A held result freezes the whole pipeline; the input stage still fills if empty.
module ray_ray_intersection_test
    import rri_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_en,
    input  logic [THR_WIDTH-1:0]     cfg_write_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [3*COORD_WIDTH-1:0] origin_a,
    input  logic [3*COORD_WIDTH-1:0] direction_a,
    input  logic [COORD_WIDTH-1:0]   limit_a,
    input  logic [3*COORD_WIDTH-1:0] origin_b,
    input  logic [3*COORD_WIDTH-1:0] direction_b,
    input  logic [COORD_WIDTH-1:0]   limit_b,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     intersects
);

    localparam int CW    = COORD_WIDTH;
    localparam int FB    = FRACTION_BITS;
    localparam int VW    = CW + 1;
    localparam int DCW   = 2 * CW + 1;
    localparam int CCW   = 2 * CW + 2;
    localparam int DENW  = 4 * CW;
    localparam int NSW   = 4 * CW + 2;
    localparam int MW    = 4 * CW + 1;
    localparam int RW    = MW + TPAR_FRAC;
    localparam int TW    = TPAR_BITS;
    localparam int SBW   = 14 * CW;
    localparam int PARW  = (DENW + TPAR_FRAC > THR_WIDTH + 4 * FB) ?
                           DENW + TPAR_FRAC : THR_WIDTH + 4 * FB;
    localparam int SATW  = DENW + TW - TPAR_FRAC;
    localparam int PRW   = TW + 1 + CW;
    localparam int PSW   = PRW + 1;
    localparam int ESW   = PRW + 2;
    localparam int EW    = PRW + 1;
    localparam int EHW   = EW - 32;
    localparam int SQW   = 2 * EW;
    localparam int E2W   = SQW + 2;
    localparam int CMPW  = (E2W > THR_WIDTH + TPAR_FRAC + 2 * FB) ?
                           E2W : THR_WIDTH + TPAR_FRAC + 2 * FB;
    localparam int OA_O  = 0;
    localparam int DA_O  = 3 * CW;
    localparam int OB_O  = 6 * CW;
    localparam int DB_O  = 9 * CW;
    localparam int LA_O  = 12 * CW;
    localparam int LB_O  = 13 * CW;

    logic en;
    logic load0;
    logic [THR_WIDTH-1:0] thr_reg;

    // stage 0: input register
    logic           v0_reg;
    logic [SBW-1:0] sb0_reg;
    // stage 1: direction cross product, origin difference
    logic                  v1_reg;
    logic [SBW-1:0]        sb1_reg;
    logic signed [DCW-1:0] d1_reg [3];
    logic signed [DCW-1:0] d1_next [3];
    logic signed [VW-1:0]  vd1_reg [3];
    logic signed [VW-1:0]  vd1_next [3];
    // stage 2: numerator cross products, squares of d
    logic                  v2_reg;
    logic [SBW-1:0]        sb2_reg;
    logic signed [DCW-1:0] d2_reg [3];
    logic signed [CCW-1:0] c1_2_reg [3];
    logic signed [CCW-1:0] c2_2_reg [3];
    logic signed [CCW-1:0] c1_2_next [3];
    logic signed [CCW-1:0] c2_2_next [3];
    logic [DENW-1:0]       dsq2_reg [3];
    logic [DENW-1:0]       dsq2_next [3];
    // stage 3: denominator, numerator products
    logic                  v3_reg;
    logic [SBW-1:0]        sb3_reg;
    logic [DENW-1:0]       den3_reg;
    logic signed [NSW-1:0] na3_reg [3];
    logic signed [NSW-1:0] nb3_reg [3];
    logic signed [NSW-1:0] na3_next [3];
    logic signed [NSW-1:0] nb3_next [3];
    // stage 4: signs, magnitudes, parallel and overflow tests
    logic            v4_reg;
    logic [SBW-1:0]  sb4_reg;
    logic [DENW-1:0] den4_reg;
    logic [RW-1:0]   num_a4_reg;
    logic [RW-1:0]   num_b4_reg;
    rri_flags_t      f4_reg;
    logic [RW-1:0]   num_a4_next;
    logic [RW-1:0]   num_b4_next;
    rri_flags_t      f4_next;
    // divider output
    logic           vq;
    logic [TW-1:0]  qa;
    logic [TW-1:0]  qb;
    rri_flags_t     fq;
    logic [SBW-1:0] sbq;
    // stage 5: range checks, t * direction
    logic                  v5_reg;
    logic                  live5_reg;
    logic                  live5_next;
    logic [SBW-1:0]        sb5_reg;
    logic signed [PRW-1:0] pa5_reg [3];
    logic signed [PRW-1:0] pb5_reg [3];
    logic signed [PRW-1:0] pa5_next [3];
    logic signed [PRW-1:0] pb5_next [3];
    // stage 6: closest point separation
    logic          v6_reg;
    logic          live6_reg;
    logic [EW-1:0] e6_reg [3];
    logic [EW-1:0] e6_next [3];
    // stage 7: partial products of squares
    logic             v7_reg;
    logic             live7_reg;
    logic [2*EHW-1:0] hh7_reg [3];
    logic [EW-1:0]    hl7_reg [3];
    logic [63:0]      ll7_reg [3];
    // stage 8: squares
    logic           v8_reg;
    logic           live8_reg;
    logic [SQW-1:0] sq8_reg [3];
    // stage 9: output
    logic out_valid_reg;
    logic intersects_reg;
    logic [E2W-1:0] e2_sum;

    assign en       = !out_valid_reg || out_ready;
    assign load0    = en || !v0_reg;
    assign in_ready = load0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_write_en)
        begin
            thr_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load0)
            begin
                v0_reg <= in_valid;
            end
            if (en)
            begin
                v1_reg        <= v0_reg;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                v5_reg        <= vq;
                v6_reg        <= v5_reg;
                v7_reg        <= v6_reg;
                v8_reg        <= v7_reg;
                out_valid_reg <= v8_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load0)
        begin
            sb0_reg <= {limit_b, limit_a, direction_b, origin_b, direction_a, origin_a};
        end
    end

    // stage 1
    always_comb
    begin
        logic signed [CW-1:0] da [3];
        logic signed [CW-1:0] db [3];
        logic signed [CW-1:0] oa [3];
        logic signed [CW-1:0] ob [3];
        for (int k = 0; k < 3; k++)
        begin
            da[k] = $signed(sb0_reg[DA_O + k*CW +: CW]);
            db[k] = $signed(sb0_reg[DB_O + k*CW +: CW]);
            oa[k] = $signed(sb0_reg[OA_O + k*CW +: CW]);
            ob[k] = $signed(sb0_reg[OB_O + k*CW +: CW]);
            vd1_next[k] = VW'(ob[k]) - VW'(oa[k]);
        end
        d1_next[0] = DCW'(da[1]) * DCW'(db[2]) - DCW'(da[2]) * DCW'(db[1]);
        d1_next[1] = DCW'(da[2]) * DCW'(db[0]) - DCW'(da[0]) * DCW'(db[2]);
        d1_next[2] = DCW'(da[0]) * DCW'(db[1]) - DCW'(da[1]) * DCW'(db[0]);
    end

    // stage 2
    always_comb
    begin
        logic signed [CW-1:0]    da [3];
        logic signed [CW-1:0]    db [3];
        logic signed [2*DCW-1:0] sq;
        for (int k = 0; k < 3; k++)
        begin
            da[k] = $signed(sb1_reg[DA_O + k*CW +: CW]);
            db[k] = $signed(sb1_reg[DB_O + k*CW +: CW]);
        end
        c1_2_next[0] = CCW'(vd1_reg[1]) * CCW'(db[2]) - CCW'(vd1_reg[2]) * CCW'(db[1]);
        c1_2_next[1] = CCW'(vd1_reg[2]) * CCW'(db[0]) - CCW'(vd1_reg[0]) * CCW'(db[2]);
        c1_2_next[2] = CCW'(vd1_reg[0]) * CCW'(db[1]) - CCW'(vd1_reg[1]) * CCW'(db[0]);
        c2_2_next[0] = CCW'(vd1_reg[1]) * CCW'(da[2]) - CCW'(vd1_reg[2]) * CCW'(da[1]);
        c2_2_next[1] = CCW'(vd1_reg[2]) * CCW'(da[0]) - CCW'(vd1_reg[0]) * CCW'(da[2]);
        c2_2_next[2] = CCW'(vd1_reg[0]) * CCW'(da[1]) - CCW'(vd1_reg[1]) * CCW'(da[0]);
        sq = '0;
        for (int k = 0; k < 3; k++)
        begin
            sq = (2*DCW)'(d1_reg[k]) * (2*DCW)'(d1_reg[k]);
            dsq2_next[k] = sq[DENW-1:0];
        end
    end

    // stage 3
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            na3_next[k] = NSW'(c1_2_reg[k]) * NSW'(d2_reg[k]);
            nb3_next[k] = NSW'(c2_2_reg[k]) * NSW'(d2_reg[k]);
        end
    end

    // stage 4
    always_comb
    begin
        logic signed [NSW-1:0] n_a;
        logic signed [NSW-1:0] n_b;
        logic [NSW-1:0]        abs_a;
        logic [NSW-1:0]        abs_b;
        logic [MW-1:0]         m_a;
        logic [MW-1:0]         m_b;
        n_a   = na3_reg[0] + na3_reg[1] + na3_reg[2];
        n_b   = nb3_reg[0] + nb3_reg[1] + nb3_reg[2];
        abs_a = n_a[NSW-1] ? NSW'(-n_a) : NSW'(n_a);
        abs_b = n_b[NSW-1] ? NSW'(-n_b) : NSW'(n_b);
        m_a   = abs_a[MW-1:0];
        m_b   = abs_b[MW-1:0];
        num_a4_next   = {m_a, {TPAR_FRAC{1'b0}}};
        num_b4_next   = {m_b, {TPAR_FRAC{1'b0}}};
        f4_next.neg_a = n_a[NSW-1];
        f4_next.neg_b = n_b[NSW-1];
        f4_next.sat_a = SATW'(m_a) >= (SATW'(den3_reg) << (TW - TPAR_FRAC));
        f4_next.sat_b = SATW'(m_b) >= (SATW'(den3_reg) << (TW - TPAR_FRAC));
        f4_next.live  = (den3_reg != '0) &&
                        !((PARW'(den3_reg) << TPAR_FRAC) < (PARW'(thr_reg) << (4 * FB)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb1_reg    <= sb0_reg;
            sb2_reg    <= sb1_reg;
            sb3_reg    <= sb2_reg;
            sb4_reg    <= sb3_reg;
            den3_reg   <= dsq2_reg[0] + dsq2_reg[1] + dsq2_reg[2];
            den4_reg   <= den3_reg;
            num_a4_reg <= num_a4_next;
            num_b4_reg <= num_b4_next;
            f4_reg     <= f4_next;
            for (int k = 0; k < 3; k++)
            begin
                d1_reg[k]   <= d1_next[k];
                vd1_reg[k]  <= vd1_next[k];
                d2_reg[k]   <= d1_reg[k];
                c1_2_reg[k] <= c1_2_next[k];
                c2_2_reg[k] <= c2_2_next[k];
                dsq2_reg[k] <= dsq2_next[k];
                na3_reg[k]  <= na3_next[k];
                nb3_reg[k]  <= nb3_next[k];
            end
        end
    end

    rri_div #(
        .NUM_WIDTH (RW),
        .DEN_WIDTH (DENW),
        .SB_WIDTH  (SBW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .num_a     (num_a4_reg),
        .num_b     (num_b4_reg),
        .den       (den4_reg),
        .flags_in  (f4_reg),
        .sb_in     (sb4_reg),
        .out_valid (vq),
        .quo_a     (qa),
        .quo_b     (qb),
        .flags_out (fq),
        .sb_out    (sbq)
    );

    // stage 5: all-ones limit means unlimited
    always_comb
    begin
        logic [TW-1:0]        t_a;
        logic [TW-1:0]        t_b;
        logic [CW-1:0]        lim_a;
        logic [CW-1:0]        lim_b;
        logic                 ok_a;
        logic                 ok_b;
        logic signed [CW-1:0] da;
        logic signed [CW-1:0] db;
        t_a   = fq.sat_a ? {TW{1'b1}} : qa;
        t_b   = fq.sat_b ? {TW{1'b1}} : qb;
        lim_a = sbq[LA_O +: CW];
        lim_b = sbq[LB_O +: CW];
        ok_a  = (&lim_a) || (t_a <= (TW'(lim_a) << (TPAR_FRAC - FB)));
        ok_b  = (&lim_b) || (t_b <= (TW'(lim_b) << (TPAR_FRAC - FB)));
        live5_next = fq.live && ok_a && ok_b &&
                     !(fq.neg_a && (t_a != '0)) && !(fq.neg_b && (t_b != '0));
        for (int k = 0; k < 3; k++)
        begin
            da = $signed(sbq[DA_O + k*CW +: CW]);
            db = $signed(sbq[DB_O + k*CW +: CW]);
            pa5_next[k] = PRW'($signed({1'b0, t_a})) * PRW'(da);
            pb5_next[k] = PRW'($signed({1'b0, t_b})) * PRW'(db);
        end
    end

    // stage 6
    always_comb
    begin
        logic signed [CW-1:0]  oa;
        logic signed [CW-1:0]  ob;
        logic signed [PSW-1:0] p1;
        logic signed [PSW-1:0] p2;
        logic signed [ESW-1:0] diff;
        logic [ESW-1:0]        mag;
        for (int k = 0; k < 3; k++)
        begin
            oa   = $signed(sb5_reg[OA_O + k*CW +: CW]);
            ob   = $signed(sb5_reg[OB_O + k*CW +: CW]);
            p1   = (PSW'(oa) <<< TPAR_FRAC) + PSW'(pa5_reg[k]);
            p2   = (PSW'(ob) <<< TPAR_FRAC) + PSW'(pb5_reg[k]);
            diff = ESW'(p2) - ESW'(p1);
            mag  = diff[ESW-1] ? ESW'(-diff) : ESW'(diff);
            e6_next[k] = mag[EW-1:0];
        end
    end

    always_comb
    begin
        e2_sum = E2W'(sq8_reg[0]) + E2W'(sq8_reg[1]) + E2W'(sq8_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            live5_reg <= live5_next;
            sb5_reg   <= sbq;
            live6_reg <= live5_reg;
            live7_reg <= live6_reg;
            live8_reg <= live7_reg;
            for (int k = 0; k < 3; k++)
            begin
                pa5_reg[k] <= pa5_next[k];
                pb5_reg[k] <= pb5_next[k];
                e6_reg[k]  <= e6_next[k];
                hh7_reg[k] <= (2*EHW)'(e6_reg[k][EW-1:32]) * (2*EHW)'(e6_reg[k][EW-1:32]);
                hl7_reg[k] <= EW'(e6_reg[k][EW-1:32]) * EW'(e6_reg[k][31:0]);
                ll7_reg[k] <= 64'(e6_reg[k][31:0]) * 64'(e6_reg[k][31:0]);
                sq8_reg[k] <= (SQW'(hh7_reg[k]) << 64) + (SQW'(hl7_reg[k]) << 33) +
                              SQW'(ll7_reg[k]);
            end
            intersects_reg <= live8_reg &&
                (CMPW'(e2_sum) < (CMPW'(thr_reg) << (TPAR_FRAC + 2 * FB)));
        end
    end

    assign out_valid  = out_valid_reg;
    assign intersects = intersects_reg;

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> v0_reg && out_valid && !out_ready)
        else $error("input blocked without a held result");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v0_reg)
        else $error("accepted item missing from input stage");

    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        en && v8_reg && !live8_reg |=> out_valid && !intersects)
        else $error("rejected item reported a hit");

endmodule

/* bench/ray_ray_intersection_test_tb.sv */
// Self-checking bench for ray_ray_intersection_test: directed and random ray pairs
// across several threshold settings, each result checked against a local predictor.
// Depends on rri_pkg and the ray_ray_intersection_test RTL.
module ray_ray_intersection_test_tb;
    import rri_pkg::*;

    typedef logic signed [127:0] wint_t;

    localparam int    LATENCY     = 50;
    localparam int    CYCLE_LIMIT = 600000;
    localparam wint_t T_CAP       = wint_t'(40'hFF_FFFF_FFFF);
    localparam logic [15:0] NO_LIMIT = 16'hFFFF;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [THR_WIDTH-1:0] cfg_write_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [47:0]          origin_a;
    logic [47:0]          direction_a;
    logic [15:0]          limit_a;
    logic [47:0]          origin_b;
    logic [47:0]          direction_b;
    logic [15:0]          limit_b;
    logic                 out_valid;
    logic                 out_ready;
    logic                 intersects;

    logic [THR_WIDTH-1:0] threshold;
    bit                   hit_q[$];
    int                   errors;
    int                   cycles;
    bit                   send_bursty;
    bit                   recv_bursty;

    ray_ray_intersection_test u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .origin_a       (origin_a),
        .direction_a    (direction_a),
        .limit_a        (limit_a),
        .origin_b       (origin_b),
        .direction_b    (direction_b),
        .limit_b        (limit_b),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .intersects     (intersects)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [47:0] vec(input int x, input int y, input int z);
        logic [15:0] cx, cy, cz;
        cx = x[15:0];
        cy = y[15:0];
        cz = z[15:0];
        return {cz, cy, cx};
    endfunction

    // Parameter of the closest point, Q24.16; ok is low for a rejected negative.
    function automatic wint_t ray_param(input wint_t c[3], input wint_t d[3], input wint_t den,
                                        output bit ok);
        wint_t n, m, q;
        n = c[0] * d[0] + c[1] * d[1] + c[2] * d[2];
        m = (n < 0) ? -n : n;
        q = (m <<< 16) / den;
        if (q > T_CAP)
            q = T_CAP;
        ok = !(n < 0 && q != 0);
        return q;
    endfunction

    function automatic bit limit_ok(input wint_t t, input logic [15:0] lim);
        return (lim == NO_LIMIT) || (t <= (wint_t'(lim) <<< 8));
    endfunction

    function automatic bit rays_meet(input logic [47:0] oa_p, input logic [47:0] da_p,
                                     input logic [15:0] la, input logic [47:0] ob_p,
                                     input logic [47:0] db_p, input logic [15:0] lb,
                                     input logic [31:0] thr);
        wint_t oa[3], da[3], ob[3], db[3], d[3], v[3], c1[3], c2[3];
        wint_t den, thr_w, e2, ta, tb, p1, p2, e;
        bit ok_a, ok_b;
        int k1, k2;
        thr_w = wint_t'(thr);
        for (int k = 0; k < 3; k++)
        begin
            oa[k] = wint_t'($signed(oa_p[k*16 +: 16]));
            da[k] = wint_t'($signed(da_p[k*16 +: 16]));
            ob[k] = wint_t'($signed(ob_p[k*16 +: 16]));
            db[k] = wint_t'($signed(db_p[k*16 +: 16]));
            v[k]  = ob[k] - oa[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            k1 = (k + 1) % 3;
            k2 = (k + 2) % 3;
            d[k]  = da[k1] * db[k2] - da[k2] * db[k1];
            c1[k] = v[k1] * db[k2] - v[k2] * db[k1];
            c2[k] = v[k1] * da[k2] - v[k2] * da[k1];
        end
        den = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        if (den == 0)
            return 1'b0;
        if ((den <<< 16) < (thr_w <<< 32))
            return 1'b0;
        ta = ray_param(c1, d, den, ok_a);
        tb = ray_param(c2, d, den, ok_b);
        if (!ok_a || !ok_b)
            return 1'b0;
        if (!limit_ok(ta, la) || !limit_ok(tb, lb))
            return 1'b0;
        e2 = 0;
        for (int k = 0; k < 3; k++)
        begin
            p1 = (oa[k] <<< 16) + ta * da[k];
            p2 = (ob[k] <<< 16) + tb * db[k];
            e  = (p2 > p1) ? p2 - p1 : p1 - p2;
            e2 = e2 + e * e;
        end
        return e2 < (thr_w <<< 32);
    endfunction

    task automatic send_pair(input logic [47:0] oa, input logic [47:0] da, input logic [15:0] la,
                             input logic [47:0] ob, input logic [47:0] db, input logic [15:0] lb);
        int gap;
        if ($urandom_range(0, 63) == 0)
            send_bursty = !send_bursty;
        gap = send_bursty ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        origin_a    = oa;
        direction_a = da;
        limit_a     = la;
        origin_b    = ob;
        direction_b = db;
        limit_b     = lb;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        hit_q.push_back(rays_meet(oa, da, la, ob, db, lb, threshold));
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (hit_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [31:0] value);
        drain();
        cfg_write_en   = 1'b1;
        cfg_write_data = value;
        @(negedge clk);
        cfg_write_en = 1'b0;
        threshold    = value;
    endtask

    function automatic logic [15:0] pick_limit(input int t);
        case ($urandom_range(0, 5))
            0:       return NO_LIMIT;
            1:       return 16'($urandom);
            2:       return 16'(t * 256);
            3:       return 16'(t * 256 - 1);
            default: return 16'(t * 256 + $urandom_range(0, 600));
        endcase
    endfunction

    // Mostly pairs built to cross at a chosen point, some perturbed, some noise.
    task automatic send_random(input int n);
        int p[3], da[3], db[3], oa[3], ob[3], ta, tb, sel, span;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 15)
            begin
                send_pair(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), 16'($urandom),
                          48'({$urandom, $urandom}), 48'({$urandom, $urandom}), 16'($urandom));
            end
            else
            begin
                span = ($urandom_range(0, 9) == 0) ? 4000 : 512;
                ta = $urandom_range(0, 4);
                tb = $urandom_range(0, 4);
                for (int k = 0; k < 3; k++)
                begin
                    p[k]  = $urandom_range(0, 16000) - 8000;
                    da[k] = $urandom_range(0, 2 * span) - span;
                    db[k] = $urandom_range(0, 2 * span) - span;
                    oa[k] = p[k] - ta * da[k];
                    ob[k] = p[k] - tb * db[k];
                    if (sel >= 85)
                        ob[k] = ob[k] + $urandom_range(0, 6) - 3;
                end
                if ($urandom_range(0, 19) == 0)
                    db = da;
                send_pair(vec(oa[0], oa[1], oa[2]), vec(da[0], da[1], da[2]), pick_limit(ta),
                          vec(ob[0], ob[1], ob[2]), vec(db[0], db[1], db[2]), pick_limit(tb));
            end
        end
    endtask

    task automatic test_directed();
        logic [47:0] ex, ey, zero;
        ex   = vec(256, 0, 0);
        ey   = vec(0, 256, 0);
        zero = '0;
        send_pair(zero, ex, NO_LIMIT, vec(256, -256, 0), ey, NO_LIMIT);
        send_pair(zero, ex, 16'd128, vec(256, -256, 0), ey, NO_LIMIT);
        send_pair(zero, ex, 16'd256, vec(256, -256, 0), ey, 16'd256);
        send_pair(zero, ex, 16'd255, vec(256, -256, 0), ey, NO_LIMIT);
        send_pair(zero, ex, NO_LIMIT, vec(0, 256, 0), ex, NO_LIMIT);
        send_pair(zero, zero, NO_LIMIT, vec(256, -256, 0), ey, NO_LIMIT);
        send_pair(zero, zero, NO_LIMIT, zero, zero, NO_LIMIT);
        send_pair(zero, ex, NO_LIMIT, vec(256, -256, 256), ey, NO_LIMIT);
        send_pair(zero, ex, NO_LIMIT, vec(-256, -256, 0), ey, NO_LIMIT);
        send_pair(zero, ex, NO_LIMIT, vec(256, 256, 0), ey, NO_LIMIT);
        send_pair(zero, vec(32767, 0, 0), NO_LIMIT, vec(-1, -1, 0), vec(0, 32767, 0), NO_LIMIT);
        send_pair(zero, vec(1, 0, 0), NO_LIMIT, vec(32767, 0, 0), vec(1, 1, 0), NO_LIMIT);
        send_pair(vec(-32768, -32768, -32768), vec(1, 0, 0), 16'hFFFE,
                  vec(32767, 32767, 32767), vec(0, 0, 1), 16'hFFFE);
        send_pair(vec(32767, 32767, 32767), vec(-32768, 32767, 0), NO_LIMIT,
                  vec(-32768, -32768, -32768), vec(32767, -32768, 1), NO_LIMIT);
        send_pair('1, '1, '1, '1, vec(0, 1, 0), '1);
        send_pair('1, vec(-32768, 0, 0), 16'h0000, zero, vec(0, -32768, 0), 16'h0000);
        send_pair(zero, vec(512, 512, 0), NO_LIMIT, vec(512, 0, 0), vec(-512, 512, 0), 16'd128);
        send_pair(zero, vec(512, 512, 0), 16'd127, vec(512, 0, 0), vec(-512, 512, 0), 16'd128);
    endtask

    task automatic test_default_threshold();
        send_random(450);
    endtask

    task automatic test_zero_threshold();
        write_threshold(32'd0);
        test_directed();
        send_random(250);
    endtask

    task automatic test_max_threshold();
        write_threshold(32'hFFFF_FFFF);
        test_directed();
        send_random(250);
    endtask

    task automatic test_mid_thresholds();
        write_threshold(32'h0001_0000);
        send_random(250);
        write_threshold($urandom);
        send_random(200);
        write_threshold(32'h0000_0100 + $urandom_range(0, 255));
        send_random(200);
    endtask

    always
    begin : result_check
        int stall;
        bit want;
        if ($urandom_range(0, 63) == 0)
            recv_bursty = !recv_bursty;
        stall = recv_bursty ? 0 : $urandom_range(0, 7);
        if (stall > 0)
        begin
            out_ready = 1'b0;
            repeat (stall) @(negedge clk);
        end
        out_ready = 1'b1;
        do
            @(posedge clk);
        while (!(out_valid && rst_n));
        if (hit_q.size() == 0)
        begin
            $error("intersects: unexpected item, actual %0b", intersects);
            errors++;
        end
        else
        begin
            want = hit_q.pop_front();
            if (intersects !== want)
            begin
                $error("intersects: expected %0b actual %0b", want, intersects);
                errors++;
            end
        end
        @(negedge clk);
    end

    initial
    begin
        errors         = 0;
        cycles         = 0;
        send_bursty    = 1'b0;
        recv_bursty    = 1'b0;
        threshold      = THR_RESET;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        origin_a       = '0;
        direction_a    = '0;
        limit_a        = '0;
        origin_b       = '0;
        direction_b    = '0;
        limit_b        = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_default_threshold();
        test_zero_threshold();
        test_max_threshold();
        test_mid_thresholds();
        drain();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
